// ===== rtl/rtrg_pkg.sv =====
// ----------------------------------------------------------------------------
// rtrg_pkg
// types, constants and the output tempering function of the reduced twister
// ----------------------------------------------------------------------------
package rtrg_pkg;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned RAND_W  = 7;

   localparam logic [WORD_W-1:0] TWIST_XOR = 16'hB0DF;
   localparam logic [WORD_W-1:0] SEED_MUL  = 16'hB0DF;
   localparam logic [WORD_W-1:0] HIGH_BIT  = 16'h8000;
   localparam logic [WORD_W-1:0] LOW_BITS  = 16'h7FFF;
   localparam logic [WORD_W-1:0] TEMPER_B  = 16'h9BFF;
   localparam logic [WORD_W-1:0] TEMPER_C  = 16'hA59B;

   // request codes
   localparam logic ACT_SEED = 1'b0;
   localparam logic ACT_DRAW = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SD_MUL = 8'b0000_0010,
      ST_SD_WR  = 8'b0000_0100,
      ST_RF_PRE = 8'b0000_1000,
      ST_RF_RD  = 8'b0001_0000,
      ST_RF_WR  = 8'b0010_0000,
      ST_DR_RD  = 8'b0100_0000,
      ST_DR_OUT = 8'b1000_0000
   } state_type;

   // 16-bit tempering, low seven bits kept
   function automatic logic [RAND_W-1:0] temper(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] y;
      y = word;
      y = y ^ (y >> 5);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 1);
      return y[RAND_W-1:0];
   endfunction

endpackage

// ===== rtl/reduced_twister_random_generator_core.sv =====
// ----------------------------------------------------------------------------
// reduced_twister_random_generator_core
// draw: a read state, then tempered into the output; one draw in flight at a time
// a draw that finds the read index exhausted first refills the store: one
// prefetch state, then a read and a compute and write-back state per word
// reseed: word 0 takes the seed; each later word gets a multiply and a write state
// reset: store reads as zero through per-word valid bits, read index zero
// ----------------------------------------------------------------------------
module reduced_twister_random_generator_core #(
   parameter int unsigned STATE_WORDS  = 17,
   parameter int unsigned TWIST_OFFSET = 397
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [rtrg_pkg::WORD_W-1:0]       req_seed_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rtrg_pkg::RAND_W-1:0]       rsp_random_value
);
   import rtrg_pkg::*;

   localparam int unsigned AW        = $clog2(STATE_WORDS);
   localparam int unsigned IW        = $clog2(STATE_WORDS + 1);
   localparam int unsigned SRC_START = TWIST_OFFSET % STATE_WORDS;

   localparam logic [AW-1:0] LAST_ADDR = AW'(STATE_WORDS - 1);
   localparam logic [IW-1:0] IDX_END   = IW'(STATE_WORDS);

   // state store, read data registered on both ports
   logic [WORD_W-1:0] mem [STATE_WORDS];
   logic [STATE_WORDS-1:0] vld_ff, vld_in;
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff;
   logic              rd_a_vld_ff, rd_b_vld_ff;
   logic [AW-1:0]     rd_a_addr, rd_b_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] a_data, b_data;

   // control
   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in;       // read index, STATE_WORDS means exhausted
   logic [AW-1:0]     cnt_ff, cnt_in;       // word being seeded or refilled
   logic [AW-1:0]     src_ff, src_in;       // twist source word during refill
   logic [AW-1:0]     nxt_addr;
   logic [WORD_W-1:0] w_ff, w_in;           // previous seed word
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] cur_ff, cur_in;       // word i before rewrite
   logic [2*WORD_W-1:0] prod_full;
   logic [WORD_W-1:0] twist_y, twist_v;
   logic              out_vld_ff, out_vld_in;
   logic [RAND_W-1:0] out_ff, out_in;
   logic              req_xfer, out_free;

   assign req_stall        = (state_ff != ST_IDLE);
   assign req_xfer         = req_valid && !req_stall;
   assign rsp_valid        = out_vld_ff;
   assign rsp_random_value = out_ff;
   assign out_free         = !out_vld_ff || !rsp_stall;

   // entries never written read as zero
   assign a_data = rd_a_vld_ff ? rd_a_ff : '0;
   assign b_data = rd_b_vld_ff ? rd_b_ff : '0;

   assign nxt_addr  = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + AW'(1);
   assign prod_full = 32'(SEED_MUL) * 32'(w_ff ^ (w_ff >> 15));

   // twist of word i: top bit of word i, low bits of word i+1, source word
   assign twist_y = (cur_ff & HIGH_BIT) | (a_data & LOW_BITS);
   assign twist_v = b_data ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      src_in     = src_ff;
      w_in       = w_ff;
      prod_in    = prod_ff;
      cur_in     = cur_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      out_in     = out_ff;
      vld_in     = vld_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = req_seed_value;
      rd_a_addr  = nxt_addr;
      rd_b_addr  = src_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_action == ACT_SEED) begin
                  // word 0 takes the seed right away
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_seed_value;
                  w_in     = req_seed_value;
                  cnt_in   = AW'(1);
                  state_in = ST_SD_MUL;
               end else if (idx_ff >= IDX_END) begin
                  cnt_in   = '0;
                  src_in   = AW'(SRC_START);
                  state_in = ST_RF_PRE;
               end else begin
                  state_in = ST_DR_RD;
               end
            end
         end
         ST_SD_MUL: begin
            prod_in  = prod_full[WORD_W-1:0];
            state_in = ST_SD_WR;
         end
         ST_SD_WR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = prod_ff + WORD_W'(cnt_ff);
            w_in    = wr_data;
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = ST_SD_MUL;
            end
         end
         ST_RF_PRE: begin
            // fetch word 0 ahead of the first refill step
            rd_a_addr = '0;
            state_in  = ST_RF_RD;
         end
         ST_RF_RD: begin
            // port a still holds word i from the previous read
            cur_in   = a_data;
            state_in = ST_RF_WR;
         end
         ST_RF_WR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = twist_v;
            if (cnt_ff == LAST_ADDR) begin
               idx_in   = '0;
               state_in = ST_DR_RD;
            end else begin
               cnt_in   = nxt_addr;
               src_in   = (src_ff == LAST_ADDR) ? '0 : src_ff + AW'(1);
               state_in = ST_RF_RD;
            end
         end
         ST_DR_RD: begin
            rd_a_addr = idx_ff[AW-1:0];
            state_in  = ST_DR_OUT;
         end
         ST_DR_OUT: begin
            // hold the read address so the data stays while the output waits
            rd_a_addr = idx_ff[AW-1:0];
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in     = temper(a_data);
               idx_in     = idx_ff + IW'(1);
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   // state store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff     <= mem[rd_a_addr];
      rd_b_ff     <= mem[rd_b_addr];
      rd_a_vld_ff <= vld_ff[rd_a_addr];
      rd_b_vld_ff <= vld_ff[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         src_ff     <= '0;
         out_vld_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         src_ff     <= src_in;
         out_vld_ff <= out_vld_in;
         vld_ff     <= vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      prod_ff <= prod_in;
      cur_ff  <= cur_in;
      out_ff  <= out_in;
   end

endmodule

// ===== dv/tb_rng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rng_pkg
// predicts the reduced twister's draws and scores the values the core returns
// ----------------------------------------------------------------------------
package tb_rng_pkg;

   localparam int unsigned STORE_DEPTH = 17;
   localparam int unsigned TWIST_SPAN  = 397;
   localparam int unsigned MAX_LINES   = 50;

   class random_value_scoreboard;

      bit [rtrg_pkg::WORD_W-1:0] store_words [STORE_DEPTH];
      int unsigned               read_pos;
      bit [rtrg_pkg::RAND_W-1:0] expected_values [$];
      int unsigned               errors;

      function new();
         foreach (store_words[i]) store_words[i] = '0;
         read_pos = 0;
         errors   = 0;
      endfunction

      function void report(string msg);
         if (errors < MAX_LINES) $display("%0t ns: %s", $realtime, msg);
         errors++;
      endfunction

      function void reseed_store(bit [rtrg_pkg::WORD_W-1:0] seed);
         bit [rtrg_pkg::WORD_W-1:0] w;
         bit [31:0]                 prod;
         store_words[0] = seed;
         for (int unsigned i = 1; i < STORE_DEPTH; i++) begin
            w    = store_words[i-1];
            prod = 32'(rtrg_pkg::SEED_MUL) * 32'(w ^ (w >> 15)) + 32'(i);
            store_words[i] = prod[rtrg_pkg::WORD_W-1:0];
         end
      endfunction

      // in place, so later words see the ones already rewritten
      function void refill_store();
         bit [rtrg_pkg::WORD_W-1:0] y;
         bit [rtrg_pkg::WORD_W-1:0] v;
         int unsigned               nxt;
         int unsigned               src;
         for (int unsigned i = 0; i < STORE_DEPTH; i++) begin
            nxt = (i + 1) % STORE_DEPTH;
            src = (i + TWIST_SPAN) % STORE_DEPTH;
            y = (store_words[i] & rtrg_pkg::HIGH_BIT) |
                (store_words[nxt] & rtrg_pkg::LOW_BITS);
            v = store_words[src] ^ (y >> 1);
            if (y[0]) v = v ^ rtrg_pkg::TWIST_XOR;
            store_words[i] = v;
         end
         read_pos = 0;
      endfunction

      function bit [rtrg_pkg::RAND_W-1:0] temper_word(bit [rtrg_pkg::WORD_W-1:0] w);
         bit [rtrg_pkg::WORD_W-1:0] y;
         y = w;
         y = y ^ (y >> 5);
         y = y ^ ((y << 7) & rtrg_pkg::TEMPER_B);
         y = y ^ ((y << 15) & rtrg_pkg::TEMPER_C);
         y = y ^ (y >> 1);
         return y[rtrg_pkg::RAND_W-1:0];
      endfunction

      function void note_transfer(logic action, logic [rtrg_pkg::WORD_W-1:0] seed);
         if (action == rtrg_pkg::ACT_SEED) begin
            reseed_store(seed);
         end else begin
            if (read_pos >= STORE_DEPTH) refill_store();
            expected_values.push_back(temper_word(store_words[read_pos]));
            read_pos++;
         end
      endfunction

      function void check_value(logic [rtrg_pkg::RAND_W-1:0] got);
         bit [rtrg_pkg::RAND_W-1:0] want;
         if (expected_values.size() == 0) begin
            report($sformatf("random_value 0x%02h with no draw outstanding", got));
         end else begin
            want = expected_values.pop_front();
            if (got !== want)
               report($sformatf("random_value mismatch: expected 0x%02h, got 0x%02h",
                                want, got));
         end
      endfunction

      function int unsigned outstanding();
         return expected_values.size();
      endfunction

   endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed reseed/draw traffic into the reduced twister core, with
// every returned value scored against an in-bench model of the state store
// ----------------------------------------------------------------------------
module tb_top;

   import tb_rng_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 1400;
   localparam int unsigned PHASE_ITEMS    = 100;
   localparam int unsigned LONG_HOLD      = 300;
   // refill plus reseed plus the draw pipe, with margin
   localparam int unsigned DRAIN_CYCLES   = 4 * STORE_DEPTH + 16;
   // longest legal quiet stretch is the long hold-off; several times over
   localparam int unsigned WATCHDOG_LIMIT = 4 * LONG_HOLD + 400;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_action = rtrg_pkg::ACT_DRAW;
   logic [rtrg_pkg::WORD_W-1:0] req_seed_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [rtrg_pkg::RAND_W-1:0] rsp_random_value;

   random_value_scoreboard sb = new();

   // gap controls shared between the two sides
   bit          tx_gaps_on = 1'b1;
   bit          rx_gaps_on = 1'b1;
   bit          long_hold_pending = 1'b0;
   int unsigned quiet_cycles = 0;

   reduced_twister_random_generator_core #(
      .STATE_WORDS  (STORE_DEPTH),
      .TWIST_OFFSET (TWIST_SPAN)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_seed_value   (req_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   // 12 ns period
   initial begin
      forever #6 clock = ~clock;
   end

   // offer one request and hold it until the core takes it; the gap comes
   // first so valid is never dropped and raised in the same step
   task automatic send_request(logic action, logic [rtrg_pkg::WORD_W-1:0] seed);
      int unsigned gap;
      gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid      <= 1'b0;
         // junk on the idle payload, the core must ignore it
         req_action     <= 1'($urandom_range(0, 1));
         req_seed_value <= 16'($urandom_range(0, 65535));
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_seed_value <= seed;
      do @(posedge clock); while (req_stall);
      // transfer happened at this edge
      sb.note_transfer(action, seed);
   endtask

   // seed values lean on the corners now and then
   function automatic logic [rtrg_pkg::WORD_W-1:0] pick_seed();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         4:       return 16'h0001;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // take valid down so the last request is not offered again, then wait
   // until every pending draw has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // result side: draw a hold-off, then accept one value and score it
   initial begin : rsp_side
      int unsigned hold;
      forever begin
         if (long_hold_pending) begin
            // long stall so the core backs up and stalls its request side
            hold              = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else if (rx_gaps_on) begin
            hold = $urandom_range(0, 11);
         end else begin
            hold = 0;
         end
         rsp_stall <= (hold != 0);
         if (hold != 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         sb.check_value(rsp_random_value);
      end
   end

   // quiet-cycle watchdog, any transfer on either side resets it
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("reduced_twister_random_generator_core test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned burst_left;
      int unsigned mode;
      logic        action;

      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // draws straight out of reset read the all-zero store
      repeat (3) send_request(rtrg_pkg::ACT_DRAW, pick_seed());
      // reseed corners, each followed by a draw; read index keeps counting
      send_request(rtrg_pkg::ACT_SEED, 16'hFFFF);
      send_request(rtrg_pkg::ACT_DRAW, 16'h0000);
      send_request(rtrg_pkg::ACT_SEED, 16'h0000);
      send_request(rtrg_pkg::ACT_DRAW, 16'hFFFF);
      send_request(rtrg_pkg::ACT_SEED, 16'h8000);
      send_request(rtrg_pkg::ACT_DRAW, 16'h7FFF);
      send_request(rtrg_pkg::ACT_SEED, 16'h7FFF);
      send_request(rtrg_pkg::ACT_DRAW, 16'h8000);
      send_request(rtrg_pkg::ACT_SEED, 16'h0001);
      // run the index past the end of the store so a refill happens
      repeat (12) send_request(rtrg_pkg::ACT_DRAW, pick_seed());
      // back-to-back reseeds with no draw between
      send_request(rtrg_pkg::ACT_SEED, 16'hA5A5);
      send_request(rtrg_pkg::ACT_SEED, 16'h5A5A);
      wait_drained();

      // ---- random ----
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         // new gap pattern every phase: both, sender only, receiver only, none
         if (n % PHASE_ITEMS == 0) begin
            mode       = $urandom_range(0, 3);
            tx_gaps_on = mode[0];
            rx_gaps_on = mode[1];
         end
         // receiver goes quiet for a long stretch while requests keep coming
         if (n == 350) begin
            long_hold_pending = 1'b1;
            burst_left        = 60;
         end
         // sender stops until every pending draw has come back
         if (n == 700 || n == 1100) wait_drained();
         if (burst_left != 0) begin
            tx_gaps_on = 1'b0;
            burst_left--;
         end
         // mostly draws, with reseeds scattered and occasionally clustered
         action = ($urandom_range(0, 99) < 10) ? rtrg_pkg::ACT_SEED : rtrg_pkg::ACT_DRAW;
         send_request(action, pick_seed());
      end

      // ---- drain ----
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("reduced_twister_random_generator_core test passed");
      end else begin
         $display("reduced_twister_random_generator_core test failed");
      end
      $finish;
   end

endmodule
